// File: src/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

  // default table depth
  localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

  // field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned CNT_W  = 11;

  // configuration port
  localparam int unsigned APB_ADDR_W = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] REG_ELEMENT_COUNT = 2'd0;

  // request opcodes
  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } opcode_t;

  // table value type
  typedef logic signed [DATA_W-1:0] value_t;

endpackage

`default_nettype wire

// File: src/sorted_table_binary_search_top.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted value table with binary search and equal-run widening.
// ----------------------------------------------------------------------------
//
//  channel   signals                                        handshake
//  --------  ---------------------------------------------  ------------------
//  request   opcode entry_index entry_value search_key      start && !busy
//  result    found hit_index run_first run_last             done (one cycle)
//  config    psel penable pwrite paddr pwdata prdata pready  apb, pready = 1
//
//  a write request leaves busy low, so requests may follow back to back. a
//  search probes midpoints until a hit or an empty range, then widens the
//  hit upward and then downward over equal neighbors; every probe and every
//  neighbor check is one read of the value table plus one compare.
//  reset clears the sequencer and element_count; table contents are unknown
//  until written. the result cannot be stalled: done pulses for one cycle.
//
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search_top #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // request
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              opcode,
  input  wire logic [stbs_pkg::IDX_W-1:0]        entry_index,
  input  wire logic signed [stbs_pkg::DATA_W-1:0] entry_value,
  input  wire logic signed [stbs_pkg::DATA_W-1:0] search_key,
  // result
  output logic                                   done,
  output logic                                   found,
  output logic [stbs_pkg::IDX_W-1:0]             hit_index,
  output logic [stbs_pkg::IDX_W-1:0]             run_first,
  output logic [stbs_pkg::IDX_W-1:0]             run_last,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [stbs_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [stbs_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [stbs_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int unsigned CNT_W = stbs_pkg::CNT_W;
  localparam int unsigned IDX_W = stbs_pkg::IDX_W;
  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned CAP   = (TABLE_DEPTH < CNT_MAX) ? TABLE_DEPTH : CNT_MAX;
  localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_PCMP,
    S_UP,
    S_UCMP,
    S_DOWN,
    S_DCMP
  } state_t;

  state_t state;

  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hx;
  logic [CNT_W-1:0] mid_r;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] z;
  logic [CNT_W-1:0] ap;
  stbs_pkg::value_t key;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] ap_dec;
  logic             accept;
  logic             cfg_wr;
  logic             wr_ok;
  logic             wr_en;
  logic             rd_en;
  logic [CNT_W-1:0] rd_idx;
  stbs_pkg::value_t rd_data;
  logic             cmp_eq;
  logic             cmp_gt;

  // request acceptance
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign wr_ok  = (32'(entry_index) < 32'(TABLE_DEPTH));
  assign wr_en  = accept && (opcode == stbs_pkg::OP_WRITE) && wr_ok;

  // probe midpoint of [lo, hx-1]
  assign mid_sum = {1'b0, lo} + {1'b0, hx} - {{CNT_W{1'b0}}, 1'b1};
  assign mid     = mid_sum[CNT_W:1];
  assign ap_dec  = ap - {{(CNT_W-1){1'b0}}, 1'b1};

  // table read address and enable
  always_comb begin
    rd_en  = 1'b0;
    rd_idx = mid;
    unique case (state)
      S_PROBE: begin
        rd_en  = (lo < hx);
        rd_idx = mid;
      end
      S_UP: begin
        rd_en  = (z < n);
        rd_idx = z;
      end
      S_DOWN: begin
        rd_en  = (ap != '0);
        rd_idx = ap_dec;
      end
      default: begin
        rd_en  = 1'b0;
        rd_idx = mid;
      end
    endcase
  end

  // shared compare unit
  assign cmp_eq = (rd_data == key);
  assign cmp_gt = (rd_data > key);

  stbs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(entry_index)),
    .wr_data (entry_value),
    .rd_en   (rd_en),
    .rd_addr (AW'(rd_idx)),
    .rd_data (rd_data)
  );

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr == stbs_pkg::REG_ELEMENT_COUNT);
  assign prdata = (paddr == stbs_pkg::REG_ELEMENT_COUNT) ?
                  stbs_pkg::APB_DATA_W'(element_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else if (cfg_wr) begin
      element_count <= pwdata[CNT_W-1:0];
    end
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && (opcode == stbs_pkg::OP_SEARCH)) begin
            key   <= search_key;
            n     <= (element_count > CAP_V) ? CAP_V : element_count;
            lo    <= '0;
            hx    <= (element_count > CAP_V) ? CAP_V : element_count;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hx) begin
            mid_r <= mid;
            state <= S_PCMP;
          end else begin
            // miss
            done      <= 1'b1;
            found     <= 1'b0;
            hit_index <= '0;
            run_first <= '0;
            run_last  <= '0;
            state     <= S_IDLE;
          end
        end
        S_PCMP: begin
          if (cmp_eq) begin
            pos   <= mid_r;
            z     <= mid_r + {{(CNT_W-1){1'b0}}, 1'b1};
            ap    <= mid_r;
            state <= S_UP;
          end else if (cmp_gt) begin
            hx    <= mid_r;
            state <= S_PROBE;
          end else begin
            lo    <= mid_r + {{(CNT_W-1){1'b0}}, 1'b1};
            state <= S_PROBE;
          end
        end
        // widen upward
        S_UP: begin
          state <= (z < n) ? S_UCMP : S_DOWN;
        end
        S_UCMP: begin
          if (cmp_eq) begin
            z     <= z + {{(CNT_W-1){1'b0}}, 1'b1};
            state <= S_UP;
          end else begin
            state <= S_DOWN;
          end
        end
        // widen downward, finish when the run ends
        S_DOWN: begin
          if (ap != '0) begin
            state <= S_DCMP;
          end else begin
            done      <= 1'b1;
            found     <= 1'b1;
            hit_index <= pos[IDX_W-1:0];
            run_first <= ap[IDX_W-1:0];
            run_last  <= z[IDX_W-1:0] - {{(IDX_W-1){1'b0}}, 1'b1};
            state     <= S_IDLE;
          end
        end
        S_DCMP: begin
          if (cmp_eq) begin
            ap    <= ap_dec;
            state <= S_DOWN;
          end else begin
            done      <= 1'b1;
            found     <= 1'b1;
            hit_index <= pos[IDX_W-1:0];
            run_first <= ap[IDX_W-1:0];
            run_last  <= z[IDX_W-1:0] - {{(IDX_W-1){1'b0}}, 1'b1};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/stbs_table.sv
// ----------------------------------------------------------------------------
// stbs_table
// Value table with a write port and a registered read port: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stbs_table #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire stbs_pkg::value_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output stbs_pkg::value_t     rd_data
);

  stbs_pkg::value_t mem [TABLE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted table binary search block. Requests load
// table entries and run lookups; each result is checked against a typed
// directed expectation or a behavioral lookup kept in the bench. A short
// directed table runs first, then random phases that reload sorted (sometimes
// scrambled) contents under several counts, incl. a full table and a saturated one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import stbs_pkg::*;

  localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
  localparam int RANDOM_ITEMS = 800;
  localparam int SETTLE       = 4;
  localparam int DRAIN        = 64;
  // a lookup over one run of equal values spanning the full table reads every
  // entry; the limit leaves room for many of those plus all the gaps
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int PRINT_LIMIT  = 100;

  localparam value_t VMIN = 32'sh8000_0000;
  localparam value_t VMAX = 32'sh7fff_ffff;
  localparam value_t NEG5 = -32'sd5;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] hit_index;
    logic [IDX_W-1:0] run_first;
    logic [IDX_W-1:0] run_last;
  } lookup_t;

  localparam lookup_t MISS = '0;
  localparam lookup_t HIT0 = '{1'b1, 10'd0, 10'd0, 10'd0};

  typedef enum logic {
    ROW_CFG = 1'b0,
    ROW_REQ = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    opcode_t          op;
    logic [IDX_W-1:0] idx;
    value_t           value;
    value_t           key;
    logic [CNT_W-1:0] cnt;
    logic             typed;
    lookup_t          want;
  } dir_row_t;

  // directed requests: empty table, extremes, duplicate runs, unsorted contents
  localparam dir_row_t DIR_ROWS [22] = '{
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, 32'sd0, 11'd0, 1'b1, MISS}, // empty table
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, VMIN,   11'd0, 1'b1, MISS},
    '{ROW_REQ, OP_WRITE,  10'd1023, VMAX,   32'sd0, 11'd0, 1'b0, MISS},
    '{ROW_REQ, OP_WRITE,  10'd0,    VMIN,   32'sd0, 11'd0, 1'b0, MISS},
    '{ROW_CFG, OP_WRITE,  10'd0,    32'sd0, 32'sd0, 11'd1, 1'b0, MISS},
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, VMIN,   11'd0, 1'b1, HIT0}, // single entry
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, VMAX,   11'd0, 1'b1, MISS},
    '{ROW_REQ, OP_WRITE,  10'd1,    NEG5,   32'sd0, 11'd0, 1'b0, MISS},
    '{ROW_REQ, OP_WRITE,  10'd2,    NEG5,   32'sd0, 11'd0, 1'b0, MISS},
    '{ROW_REQ, OP_WRITE,  10'd3,    NEG5,   32'sd0, 11'd0, 1'b0, MISS},
    '{ROW_REQ, OP_WRITE,  10'd4,    VMAX,   32'sd0, 11'd0, 1'b0, MISS},
    '{ROW_REQ, OP_WRITE,  10'd5,    VMAX,   32'sd0, 11'd0, 1'b0, MISS},
    '{ROW_CFG, OP_WRITE,  10'd0,    32'sd0, 32'sd0, 11'd6, 1'b0, MISS},
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, NEG5,   11'd0, 1'b0, MISS}, // run of three
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, VMAX,   11'd0, 1'b0, MISS}, // run at the top
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, VMIN,   11'd0, 1'b0, MISS},
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, 32'sd0, 11'd0, 1'b1, MISS}, // gap in values
    '{ROW_REQ, OP_WRITE,  10'd2,    32'sd100, 32'sd0, 11'd0, 1'b0, MISS}, // break order
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, NEG5,   11'd0, 1'b0, MISS},
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, 32'sd100, 11'd0, 1'b0, MISS},
    '{ROW_CFG, OP_WRITE,  10'd0,    32'sd0, 32'sd0, 11'd0, 1'b0, MISS},
    '{ROW_REQ, OP_SEARCH, 10'd0,    32'sd0, NEG5,   11'd0, 1'b1, MISS}  // emptied again
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             start       = 1'b0;
  logic             busy;
  logic             opcode      = OP_WRITE;
  logic [IDX_W-1:0] entry_index = '0;
  value_t           entry_value = '0;
  value_t           search_key  = '0;
  logic             done;
  logic             found;
  logic [IDX_W-1:0] hit_index;
  logic [IDX_W-1:0] run_first;
  logic [IDX_W-1:0] run_last;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // bench copy of the block state
  value_t           shadow_values [DEPTH];
  bit               loaded        [DEPTH];
  logic [CNT_W-1:0] elem_count = '0;

  lookup_t lookup_results [$];
  int      errors      = 0;
  int      cycle_count = 0;

  sorted_table_binary_search_top #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .entry_index(entry_index),
    .entry_value(entry_value),
    .search_key (search_key),
    .done       (done),
    .found      (found),
    .hit_index  (hit_index),
    .run_first  (run_first),
    .run_last   (run_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic flag_error(string msg);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v)
      flag_error($sformatf("%s expected %0h got %0h", name, want_v, got_v));
  endtask

  // binary search with midpoint probes, then widen the hit over equal neighbors
  function automatic lookup_t binary_lookup(value_t key);
    int      n;
    int      lo;
    int      hi;
    int      mid;
    int      pos;
    int      a;
    int      z;
    lookup_t r;
    n   = (elem_count > DEPTH) ? DEPTH : int'(elem_count);
    lo  = 0;
    hi  = n - 1;
    pos = -1;
    while (pos < 0 && lo <= hi) begin
      mid = (lo + hi) / 2;
      if (shadow_values[mid] == key) pos = mid;
      else if (shadow_values[mid] > key) hi = mid - 1;
      else lo = mid + 1;
    end
    r = MISS;
    if (pos >= 0) begin
      z = pos;
      while (z + 1 < n && shadow_values[z + 1] == key) z++;
      a = pos;
      while (a > 0 && shadow_values[a - 1] == key) a--;
      r.found     = 1'b1;
      r.hit_index = IDX_W'(pos);
      r.run_first = IDX_W'(a);
      r.run_last  = IDX_W'(z);
    end
    return r;
  endfunction

  function automatic bit all_loaded(int n);
    for (int i = 0; i < n; i++)
      if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // present one request and hold it until accepted, then update the shadow state
  task automatic send_request(opcode_t op, logic [IDX_W-1:0] idx, value_t val,
                              value_t key, logic typed, lookup_t want);
    start       <= 1'b1;
    opcode      <= op;
    entry_index <= idx;
    entry_value <= val;
    search_key  <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_WRITE) begin
      shadow_values[idx] = val;
      loaded[idx]        = 1'b1;
    end else begin
      lookup_results.push_back(typed ? want : binary_lookup(key));
    end
  endtask

  // idle the request side with junk on the fields
  task automatic pause_requests(int n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) begin
      opcode      <= 1'($urandom_range(0, 1));
      entry_index <= IDX_W'($urandom);
      entry_value <= $urandom;
      search_key  <= $urandom;
      @(posedge clk);
    end
  endtask

  // apb write of element_count once the block is idle, then read it back
  task automatic set_element_count(logic [CNT_W-1:0] cnt);
    logic [APB_DATA_W-1:0] word;
    word             = $urandom;
    word[CNT_W-1:0]  = cnt;
    start <= 1'b0;
    while (lookup_results.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ELEMENT_COUNT;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    elem_count = cnt;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("element_count readback", {{(APB_DATA_W-CNT_W){1'b0}}, cnt},
                {{(APB_DATA_W-CNT_W){1'b0}}, prdata[CNT_W-1:0]});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result check against the oldest outstanding lookup
  always @(posedge clk) begin : result_check
    lookup_t want;
    if (!rst && done === 1'b1) begin
      if (lookup_results.size() == 0) begin
        flag_error($sformatf("unexpected result found=%0b hit=%0d first=%0d last=%0d",
                             found, hit_index, run_first, run_last));
      end else begin
        want = lookup_results.pop_front();
        check_field("found", 32'(want.found), 32'(found));
        check_field("hit_index", 32'(want.hit_index), 32'(hit_index));
        check_field("run_first", 32'(want.run_first), 32'(run_first));
        check_field("run_last", 32'(want.run_last), 32'(run_last));
      end
    end
  end

  initial begin : stimulus
    int      phase;
    int      random_items;
    int      cnt_pick;
    int      eff;
    int      sel;
    int      dup_pct;
    int      step;
    int      n_ops;
    bit      quiet;
    bit      bulk;
    bit      scramble;
    longint  cur;
    value_t  key;
    value_t  val;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        set_element_count(DIR_ROWS[i].cnt);
      end else begin
        send_request(DIR_ROWS[i].op, DIR_ROWS[i].idx, DIR_ROWS[i].value,
                     DIR_ROWS[i].key, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        pause_requests(pick_gap(1'b0));
      end
    end

    // random phases; phase 6 loads the full depth, phase 7 saturates the count
    phase        = 0;
    random_items = 0;
    while (phase < 8 || random_items < RANDOM_ITEMS) begin
      if (phase == 6) begin
        cnt_pick = DEPTH;
      end else if (phase == 7) begin
        cnt_pick = (1 << CNT_W) - 1;
      end else if (phase > 7 && $urandom_range(0, 19) == 0) begin
        cnt_pick = $urandom_range(DEPTH + 1, (1 << CNT_W) - 1);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 8) cnt_pick = 0;
        else if (sel < 18) cnt_pick = 1;
        else if (sel < 26) cnt_pick = 2;
        else cnt_pick = $urandom_range(3, 48);
      end
      eff   = (cnt_pick > DEPTH) ? DEPTH : cnt_pick;
      quiet = ($urandom_range(0, 3) == 0);
      bulk  = (eff > 256);
      set_element_count(CNT_W'(cnt_pick));

      // reload the live entries: ascending with duplicate runs, or scrambled
      if (phase == 6 || !all_loaded(eff) || (!bulk && $urandom_range(0, 99) < 85)) begin
        scramble = ($urandom_range(0, 99) < 12);
        dup_pct  = $urandom_range(0, 100);
        sel      = $urandom_range(0, 3);
        if (sel == 0) cur = longint'(VMIN);
        else if (sel == 1) cur = longint'(VMAX) - $urandom_range(0, 64);
        else cur = longint'($signed($urandom));
        for (int i = 0; i < eff; i++) begin
          if (scramble) begin
            val = value_t'(int'($urandom_range(0, 7)) - 4);
          end else begin
            sel = $urandom_range(0, 99);
            if (i == 0 || sel < dup_pct) step = 0;
            else if (sel < dup_pct + (100 - dup_pct) / 2) step = $urandom_range(1, 3);
            else step = $urandom_range(1, 1 << 26);
            cur = cur + step;
            if (cur > longint'(VMAX)) cur = longint'(VMAX);
            val = cur[31:0];
          end
          send_request(OP_WRITE, IDX_W'(i), val, value_t'($urandom), 1'b0, MISS);
          random_items++;
          pause_requests(pick_gap(quiet));
        end
      end

      // lookups, mostly for stored values, with a few stray writes
      n_ops = (eff == 0) ? $urandom_range(1, 4) : $urandom_range(6, 30);
      repeat (n_ops) begin
        sel = $urandom_range(0, 99);
        if (sel < 12) begin
          send_request(OP_WRITE, IDX_W'($urandom_range(0, DEPTH - 1)), value_t'($urandom),
                       value_t'($urandom), 1'b0, MISS);
        end else begin
          sel = $urandom_range(0, 99);
          if (eff > 0 && sel < 65) begin
            key = shadow_values[$urandom_range(0, eff - 1)];
          end else if (eff > 0 && sel < 75) begin
            key = shadow_values[$urandom_range(0, eff - 1)]
                  + (($urandom_range(0, 1) == 1) ? 32'sd1 : -32'sd1);
          end else if (sel < 88) begin
            key = $urandom;
          end else if (sel < 94) begin
            key = VMIN;
          end else begin
            key = VMAX;
          end
          send_request(OP_SEARCH, IDX_W'($urandom), value_t'($urandom), key, 1'b0, MISS);
        end
        random_items++;
        pause_requests(pick_gap(quiet));
      end
      phase++;
    end

    // drain
    start <= 1'b0;
    while (lookup_results.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/stbs_pkg.sv
src/stbs_table.sv
src/sorted_table_binary_search_top.sv
dv/tb_top.sv
